### src/ensc_pkg.sv
`timescale 1ns / 1ps
package ensc_pkg;

	typedef struct packed {
		logic [19:0] raw_temp;
		logic [19:0] raw_press;
		logic [15:0] raw_hum;
	} in_item_t;

	typedef struct packed {
		logic signed [31:0] temp_centi;
		logic [31:0]        press_q24_8;
		logic [16:0]        hum_q22_10;
	} out_item_t;

	// pre-reduced terms passed from front to back
	typedef struct packed {
		logic [31:0] ta;
		logic [31:0] tb;
		logic [20:0] pn;
		logic [31:0] hl;
	} work_t;

	typedef enum logic [2:0] {
		CFG_TEMP   = 3'd0,
		CFG_PLOW   = 3'd1,
		CFG_PHIGH  = 3'd2,
		CFG_PNINE  = 3'd3,
		CFG_HUM    = 3'd4
	} cfg_idx_t;

	localparam logic [63:0] T_FINE_OFS  = 64'd128000;
	localparam logic [20:0] P_FULL      = 21'd1048576;
	localparam logic [63:0] P_SCALE     = 64'd3125;
	localparam logic [31:0] H_FINE_OFS  = 32'd76800;
	localparam logic [31:0] H_MAX       = 32'd419430400;
	localparam logic [31:0] H_INNER_OFS = 32'd2097152;
	localparam logic [31:0] H_ROUND     = 32'd16384;
	localparam logic [31:0] H_HALF      = 32'd32768;
	localparam logic [31:0] H_RIGHT_RND = 32'd8192;
	localparam int unsigned FIFO_DEPTH  = 2;

	function automatic logic [63:0] sx8(input logic [7:0] v);
		sx8 = {{56{v[7]}}, v};
	endfunction

	function automatic logic [63:0] sx12(input logic [11:0] v);
		sx12 = {{52{v[11]}}, v};
	endfunction

	function automatic logic [63:0] sx16(input logic [15:0] v);
		sx16 = {{48{v[15]}}, v};
	endfunction

	function automatic logic [63:0] sx32(input logic [31:0] v);
		sx32 = {{32{v[31]}}, v};
	endfunction

endpackage

### src/ensc_front.sv
`timescale 1ns / 1ps
module ensc_front (
	input  logic                in_valid,
	output logic                in_ready,
	input  ensc_pkg::in_item_t  in_data,
	input  logic [47:0]         temp_coeffs,
	input  logic [63:0]         hum_coeffs,
	input  logic                fifo_ready,
	output logic                push,
	output ensc_pkg::work_t     push_data
);
	logic [31:0] t1;
	logic [11:0] h4;

	assign t1 = {16'd0, temp_coeffs[15:0]};
	assign h4 = hum_coeffs[43:32];

	assign in_ready = fifo_ready;
	assign push     = in_valid & fifo_ready;

	always_comb begin
		push_data.ta = {15'd0, in_data.raw_temp[19:3]} - {t1[30:0], 1'b0};
		push_data.tb = {16'd0, in_data.raw_temp[19:4]} - t1;
		push_data.pn = ensc_pkg::P_FULL - {1'b0, in_data.raw_press};
		push_data.hl = {2'd0, in_data.raw_hum, 14'd0} - {h4, 20'd0}
			+ ensc_pkg::H_ROUND;
	end
endmodule

### src/ensc_fifo.sv
`timescale 1ns / 1ps
module ensc_fifo (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  ensc_pkg::work_t push_data,
	output logic            wr_ready,
	input  logic            pop,
	output logic            rd_valid,
	output ensc_pkg::work_t rd_data
);
	ensc_pkg::work_t mem_q [ensc_pkg::FIFO_DEPTH];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;

	assign wr_ready = count_q != 2'(ensc_pkg::FIFO_DEPTH);
	assign rd_valid = count_q != 2'd0;
	assign rd_data  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= ~wr_ptr_q;
			if (pop) rd_ptr_q <= ~rd_ptr_q;
			count_q <= count_q + {1'b0, push} - {1'b0, pop};
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= 2'(ensc_pkg::FIFO_DEPTH)) else $error("fifo count out of range");
	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == 2'(ensc_pkg::FIFO_DEPTH) && !pop) |=> !rd_valid || count_q != 2'd0)
		else $error("fifo lost entries");
	a_pop_valid: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> rd_valid) else $error("pop from empty fifo");
endmodule

### src/ensc_div.sv
`timescale 1ns / 1ps
module ensc_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] num,
	input  logic [63:0] den,
	output logic        done,
	output logic [63:0] quo
);
	logic [63:0] quo_q;
	logic [63:0] rem_q;
	logic [63:0] den_q;
	logic        neg_q;
	logic        busy_q;
	logic        done_q;
	logic [5:0]  cnt_q;
	logic [64:0] rem_sh;
	logic        fits;

	assign rem_sh = {rem_q, quo_q[63]};
	assign fits   = rem_sh >= {1'b0, den_q};
	assign done   = done_q;
	assign quo    = neg_q ? (64'd0 - quo_q) : quo_q;

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= num[63] ? (64'd0 - num) : num;
			den_q <= den[63] ? (64'd0 - den) : den;
			rem_q <= 64'd0;
			neg_q <= num[63] ^ den[63];
		end else if (busy_q) begin
			rem_q <= fits ? 64'(rem_sh - {1'b0, den_q}) : rem_sh[63:0];
			quo_q <= {quo_q[62:0], fits};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= 6'd0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 6'd0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 6'd1;
				if (cnt_q == 6'd63) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end
endmodule

### src/ensc_back.sv
`timescale 1ns / 1ps
module ensc_back (
	input  logic                clk,
	input  logic                arst_n,
	input  logic [47:0]         temp_coeffs,
	input  logic [63:0]         press_coeffs_low,
	input  logic [63:0]         press_coeffs_high,
	input  logic [15:0]         press_coeff_nine,
	input  logic [63:0]         hum_coeffs,
	input  logic                rd_valid,
	input  ensc_pkg::work_t     rd_data,
	output logic                pop,
	output logic                out_valid,
	input  logic                out_ready,
	output ensc_pkg::out_item_t out_data
);
	typedef enum logic [3:0] {
		PH_IDLE = 4'b0001,
		PH_MUL  = 4'b0010,
		PH_DIV  = 4'b0100,
		PH_OUT  = 4'b1000
	} phase_t;

	typedef enum logic [4:0] {
		ST_M1, ST_M2, ST_M3, ST_M4, ST_M5, ST_M6, ST_M7, ST_M8, ST_M9, ST_M10,
		ST_M11, ST_M12, ST_M13, ST_M14, ST_M15, ST_M16, ST_M17, ST_M18, ST_M19,
		ST_M20, ST_M21
	} step_t;

	phase_t          phase_q;
	step_t           step_q;
	ensc_pkg::work_t wk_q;
	logic [1:0]      mcnt_q;
	logic [63:0]     acc_q;
	logic [63:0]     mul_a;
	logic [63:0]     mul_b;
	logic [63:0]     term;
	logic [63:0]     prod;
	logic [31:0]     p32;

	logic [31:0] r1_q, r2_q, r3_q, tf_q, vv_q;
	logic [63:0] ww_q, w2_q, wa_q, w1d_q, pv_q;
	logic [31:0] press_q;
	logic [16:0] hum_q;
	logic        out_valid_q;
	ensc_pkg::out_item_t out_q;

	logic [63:0] w1, s64, p_pre;
	logic [31:0] v32, hv, t5;
	logic        div_start, div_done;
	logic [63:0] div_quo;

	assign w1  = ensc_pkg::sx32(tf_q) - ensc_pkg::T_FINE_OFS;
	assign s64 = $signed(pv_q) >>> 13;
	assign v32 = tf_q - ensc_pkg::H_FINE_OFS;
	assign pop = (phase_q == PH_IDLE) && rd_valid;

	// operand select: r1 and r2 are reused across the temperature and humidity chains
	always_comb begin
		mul_a = 64'd0;
		mul_b = 64'd0;
		case (step_q)
			ST_M1:  begin mul_a = ensc_pkg::sx32(wk_q.ta); mul_b = ensc_pkg::sx16(temp_coeffs[31:16]); end
			ST_M2:  begin mul_a = ensc_pkg::sx32(wk_q.tb); mul_b = ensc_pkg::sx32(wk_q.tb); end
			ST_M3:  begin mul_a = ensc_pkg::sx32(r2_q); mul_b = ensc_pkg::sx16(temp_coeffs[47:32]); end
			ST_M4:  begin mul_a = w1; mul_b = w1; end
			ST_M5:  begin mul_a = ww_q; mul_b = ensc_pkg::sx16(press_coeffs_high[31:16]); end
			ST_M6:  begin mul_a = w1; mul_b = ensc_pkg::sx16(press_coeffs_high[15:0]); end
			ST_M7:  begin mul_a = ww_q; mul_b = ensc_pkg::sx16(press_coeffs_low[47:32]); end
			ST_M8:  begin mul_a = w1; mul_b = ensc_pkg::sx16(press_coeffs_low[31:16]); end
			ST_M9:  begin
				mul_a = 64'h0000_8000_0000_0000 + wa_q;
				mul_b = {48'd0, press_coeffs_low[15:0]};
			end
			ST_M10: begin mul_a = {12'd0, wk_q.pn, 31'd0} - w2_q; mul_b = ensc_pkg::P_SCALE; end
			ST_M11: begin mul_a = ensc_pkg::sx16(press_coeff_nine); mul_b = s64; end
			ST_M12: begin mul_a = wa_q; mul_b = s64; end
			ST_M13: begin mul_a = ensc_pkg::sx16(press_coeffs_high[63:48]); mul_b = pv_q; end
			ST_M14: begin mul_a = ensc_pkg::sx12(hum_coeffs[55:44]); mul_b = ensc_pkg::sx32(v32); end
			ST_M15: begin mul_a = ensc_pkg::sx32(v32); mul_b = ensc_pkg::sx8(hum_coeffs[63:56]); end
			ST_M16: begin mul_a = ensc_pkg::sx32(v32); mul_b = {56'd0, hum_coeffs[31:24]}; end
			ST_M17: begin mul_a = ensc_pkg::sx32(r2_q); mul_b = ensc_pkg::sx32(r3_q); end
			ST_M18: begin
				mul_a = ensc_pkg::sx32(r2_q + ensc_pkg::H_INNER_OFS);
				mul_b = ensc_pkg::sx16(hum_coeffs[23:8]);
			end
			ST_M19: begin mul_a = ensc_pkg::sx32(r1_q); mul_b = ensc_pkg::sx32(r3_q); end
			ST_M20: begin
				mul_a = ensc_pkg::sx32($signed(vv_q) >>> 15);
				mul_b = ensc_pkg::sx32($signed(vv_q) >>> 15);
			end
			ST_M21: begin mul_a = ensc_pkg::sx32(r2_q); mul_b = {56'd0, hum_coeffs[7:0]}; end
			default: begin mul_a = 64'd0; mul_b = 64'd0; end
		endcase
	end

	// one 16-bit digit of the multiplier per cycle
	assign term  = 64'(mul_a * mul_b[{mcnt_q, 4'd0} +: 16]) << {mcnt_q, 4'd0};
	assign prod  = acc_q + term;
	assign p32   = prod[31:0];
	assign p_pre = pv_q + wa_q + ($signed(prod) >>> 19);
	assign hv    = vv_q - 32'($signed(p32) >>> 4);
	assign t5    = {tf_q[29:0], 2'd0} + tf_q + 32'd128;

	assign div_start = (phase_q == PH_MUL) && (step_q == ST_M10) && (mcnt_q == 2'd3);

	ensc_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (prod),
		.den    (w1d_q),
		.done   (div_done),
		.quo    (div_quo)
	);

	always_ff @(posedge clk) begin
		if (pop) wk_q <= rd_data;
		if (div_done) pv_q <= div_quo;
		if (phase_q == PH_MUL && mcnt_q == 2'd3) begin
			case (step_q)
				ST_M1:  r1_q <= $signed(p32) >>> 11;
				ST_M2:  r2_q <= $signed(p32) >>> 12;
				ST_M3:  tf_q <= r1_q + 32'($signed(p32) >>> 14);
				ST_M4:  ww_q <= prod;
				ST_M5:  w2_q <= prod;
				ST_M6:  w2_q <= w2_q + (prod << 17)
					+ (ensc_pkg::sx16(press_coeffs_low[63:48]) << 35);
				ST_M7:  wa_q <= $signed(prod) >>> 8;
				ST_M8:  wa_q <= wa_q + (prod << 12);
				ST_M9:  w1d_q <= $signed(prod) >>> 33;
				ST_M11: wa_q <= prod;
				ST_M12: wa_q <= $signed(prod) >>> 25;
				ST_M13: press_q <= 32'($signed(p_pre) >>> 8)
					+ {{12{press_coeffs_high[47]}}, press_coeffs_high[47:32], 4'd0};
				ST_M14: r1_q <= $signed(wk_q.hl - p32) >>> 15;
				ST_M15: r2_q <= $signed(p32) >>> 10;
				ST_M16: r3_q <= 32'($signed(p32) >>> 11) + ensc_pkg::H_HALF;
				ST_M17: r2_q <= $signed(p32) >>> 10;
				ST_M18: r3_q <= $signed(p32 + ensc_pkg::H_RIGHT_RND) >>> 14;
				ST_M19: vv_q <= p32;
				ST_M20: r2_q <= $signed(p32) >>> 7;
				ST_M21: begin
					if (hv[31]) hum_q <= 17'd0;
					else if (hv > ensc_pkg::H_MAX) hum_q <= ensc_pkg::H_MAX[28:12];
					else hum_q <= hv[28:12];
				end
				default: ;
			endcase
			if (step_q == ST_M9 && prod[63:33] == 31'd0) press_q <= 32'd0;
		end
		if (phase_q == PH_OUT && (!out_valid_q || out_ready)) begin
			out_q.temp_centi  <= $signed(t5) >>> 8;
			out_q.press_q24_8 <= press_q;
			out_q.hum_q22_10  <= hum_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_IDLE;
			step_q      <= ST_M1;
			mcnt_q      <= 2'd0;
			acc_q       <= 64'd0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready) out_valid_q <= 1'b0;
			unique case (phase_q)
				PH_IDLE: begin
					if (rd_valid) begin
						phase_q <= PH_MUL;
						step_q  <= ST_M1;
						mcnt_q  <= 2'd0;
						acc_q   <= 64'd0;
					end
				end
				PH_MUL: begin
					if (mcnt_q == 2'd3) begin
						mcnt_q <= 2'd0;
						acc_q  <= 64'd0;
						if (step_q == ST_M21) begin
							phase_q <= PH_OUT;
						end else if (step_q == ST_M10) begin
							phase_q <= PH_DIV;
						end else if (step_q == ST_M9 && prod[63:33] == 31'd0) begin
							// zero divisor: skip the whole divide branch
							step_q <= ST_M14;
						end else begin
							step_q <= step_t'(step_q + 5'd1);
						end
					end else begin
						mcnt_q <= mcnt_q + 2'd1;
						acc_q  <= prod;
					end
				end
				PH_DIV: begin
					if (div_done) begin
						phase_q <= PH_MUL;
						step_q  <= ST_M11;
					end
				end
				PH_OUT: begin
					if (!out_valid_q || out_ready) begin
						out_valid_q <= 1'b1;
						phase_q     <= PH_IDLE;
					end
				end
				default: phase_q <= PH_IDLE;
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	a_div_phase: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> phase_q == PH_DIV) else $error("divide result outside divide phase");
	a_pop_idle: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> phase_q == PH_MUL && step_q == ST_M1) else $error("pop did not start work");
	a_out_load: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_OUT && !out_valid_q) |=> out_valid_q)
		else $error("result not loaded into free output register");
	a_hum_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> out_q.hum_q22_10 <= 17'd102400) else $error("humidity out of range");
endmodule

### src/env_sensor_compensation.sv
`timescale 1ns / 1ps
// one reading is computed at a time; the pressure divide branch is skipped when its divisor is zero
// (multiply steps on one shared 64x16 multiplier, and a bit-serial divider for the pressure)
// the back end takes a new reading only after the previous result has moved to the output register
// a two-entry queue takes new readings while the back end works and a result waits
// reset: asynchronous active-low, clears control state and all calibration registers
module env_sensor_compensation (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  ensc_pkg::in_item_t  in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output ensc_pkg::out_item_t out_data,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [2:0]          cfg_index,
	input  logic [63:0]         cfg_data
);
	logic [47:0] temp_coeffs_q;
	logic [63:0] press_coeffs_low_q;
	logic [63:0] press_coeffs_high_q;
	logic [15:0] press_coeff_nine_q;
	logic [63:0] hum_coeffs_q;

	logic            push, fifo_ready, pop, rd_valid;
	ensc_pkg::work_t push_data, rd_data;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			temp_coeffs_q       <= 48'd0;
			press_coeffs_low_q  <= 64'd0;
			press_coeffs_high_q <= 64'd0;
			press_coeff_nine_q  <= 16'd0;
			hum_coeffs_q        <= 64'd0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				ensc_pkg::CFG_TEMP:  temp_coeffs_q       <= cfg_data[47:0];
				ensc_pkg::CFG_PLOW:  press_coeffs_low_q  <= cfg_data;
				ensc_pkg::CFG_PHIGH: press_coeffs_high_q <= cfg_data;
				ensc_pkg::CFG_PNINE: press_coeff_nine_q  <= cfg_data[15:0];
				ensc_pkg::CFG_HUM:   hum_coeffs_q        <= cfg_data;
				default: ;
			endcase
		end
	end

	ensc_front u_front (
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.in_data     (in_data),
		.temp_coeffs (temp_coeffs_q),
		.hum_coeffs  (hum_coeffs_q),
		.fifo_ready  (fifo_ready),
		.push        (push),
		.push_data   (push_data)
	);

	ensc_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.wr_ready  (fifo_ready),
		.pop       (pop),
		.rd_valid  (rd_valid),
		.rd_data   (rd_data)
	);

	ensc_back u_back (
		.clk               (clk),
		.arst_n            (arst_n),
		.temp_coeffs       (temp_coeffs_q),
		.press_coeffs_low  (press_coeffs_low_q),
		.press_coeffs_high (press_coeffs_high_q),
		.press_coeff_nine  (press_coeff_nine_q),
		.hum_coeffs        (hum_coeffs_q),
		.rd_valid          (rd_valid),
		.rd_data           (rd_data),
		.pop               (pop),
		.out_valid         (out_valid),
		.out_ready         (out_ready),
		.out_data          (out_data)
	);
endmodule
